FILE: sv/sbtsa_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and control types for the sprite batch texture slot allocator
// no dependencies

package sbtsa_pkg;

	localparam int TEXTURE_SLOTS = 32;
	localparam int IDX_W         = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
	localparam int COUNT_W       = $clog2(TEXTURE_SLOTS + 1);

	localparam int ID_W    = 32;
	localparam int SPR_W   = 16;
	localparam int SLOT_W  = 6;
	localparam int OP_W    = 1;
	localparam int IN_W    = 2 * ID_W;
	localparam int OUT_W   = 1 + SPR_W + SLOT_W + 1;

	localparam int APB_DW  = 32;
	localparam int PADDR_W = 3;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [OP_W-1:0] OP_SUBMIT = 1'b0;
	localparam logic [OP_W-1:0] OP_FLUSH  = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_SPRITE_LIMIT = 1'b0;
	localparam logic [SPR_W-1:0]     SPRITE_LIMIT_RESET = 16'd1024;
	localparam logic [SPR_W-1:0]     SPR_SAT = {SPR_W{1'b1}};

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic load_match;
		logic commit;
	} sbtsa_cmd_t;

endpackage

FILE: sv/sprite_batch_texture_slot_allocator.sv
`timescale 1ns / 1ps
// top level of the sprite batch texture slot allocator: ports, register decode
// depends on sbtsa_pkg, sbtsa_ctrl, sbtsa_dp
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------------
//  s_*      | in  | s_tvalid / s_tready     | s_tuser op; s_tdata shader_id, texture_id
//  m_*      | out | m_tvalid / m_tready     | m_tdata batch_drawn .. table_cleared
//  apb      | in  | psel & penable & pwrite | sprite limit at byte address 0
//
// each item steps through capture, compare against all table entries
// (registered match vector), then commit of state and result.
// the next item is taken once the result sits in the output register; a stalled
// output beat holds the commit cycle until m_tready frees the register.
// reset clears counts, batch and shader state; the sprite limit returns to 1024.

module sprite_batch_texture_slot_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sbtsa_pkg::IN_W-1:0]        s_tdata,   // shader_id, texture_id
	input  logic [sbtsa_pkg::OP_W-1:0]        s_tuser,   // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// batch_drawn, drawn_sprites, texture_slot, table_cleared
	output logic [sbtsa_pkg::OUT_W-1:0]       m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sbtsa_pkg::PADDR_W-1:0]     paddr,
	input  logic [sbtsa_pkg::APB_DW-1:0]      pwdata,
	output logic [sbtsa_pkg::APB_DW-1:0]      prdata,
	output logic                              pready
);
	import sbtsa_pkg::*;

	sbtsa_cmd_t         cmd;
	logic               cfg_we;
	logic               sel_max;
	logic [SPR_W-1:0]   batch_limit;

	assign pready  = 1'b1;
	assign sel_max = (paddr[PADDR_W-1:2] == REG_SPRITE_LIMIT);
	assign cfg_we  = psel && penable && pwrite && sel_max;
	assign prdata  = sel_max ? APB_DW'(batch_limit) : '0;

	sbtsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	sbtsa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_op       (s_tuser),
		.in_shader   (s_tdata[ID_W-1:0]),
		.in_texture  (s_tdata[2*ID_W-1:ID_W]),
		.cfg_we      (cfg_we),
		.cfg_data    (pwdata[SPR_W-1:0]),
		.batch_limit (batch_limit),
		.result      (m_tdata)
	);

endmodule

FILE: sv/sbtsa_ctrl.sv
`timescale 1ns / 1ps
// sequencer for one item: capture, table compare, commit into output register
// depends on sbtsa_pkg

module sbtsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output sbtsa_pkg::sbtsa_cmd_t cmd
);
	import sbtsa_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MATCH  = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d        = state_q;
		cmd.load_item  = 1'b0;
		cmd.load_match = 1'b0;
		cmd.commit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.load_match = 1'b1;
				state_d        = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the output register can take the result
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_tready))
		else $error("commit while output beat still pending");
	a_commit_shows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");
`endif

endmodule

FILE: sv/sbtsa_dp.sv
`timescale 1ns / 1ps
// datapath: texture table, batch state, sprite limit register, result register
// depends on sbtsa_pkg; driven by sbtsa_ctrl commands

module sbtsa_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sbtsa_pkg::sbtsa_cmd_t             cmd,
	input  logic [sbtsa_pkg::OP_W-1:0]        in_op,
	input  logic [sbtsa_pkg::ID_W-1:0]        in_shader,
	input  logic [sbtsa_pkg::ID_W-1:0]        in_texture,
	input  logic                              cfg_we,
	input  logic [sbtsa_pkg::SPR_W-1:0]       cfg_data,
	output logic [sbtsa_pkg::SPR_W-1:0]       batch_limit,
	output logic [sbtsa_pkg::OUT_W-1:0]       result
);
	import sbtsa_pkg::*;

	logic [ID_W-1:0]          tab_q [TEXTURE_SLOTS];
	logic [COUNT_W-1:0]       count_q;
	logic [SPR_W-1:0]         batch_q;
	logic [ID_W-1:0]          shader_q;
	logic                     known_q;
	logic [SPR_W-1:0]         max_q;

	logic [OP_W-1:0]          op_q;
	logic [ID_W-1:0]          item_shader_q;
	logic [ID_W-1:0]          item_tex_q;
	logic [TEXTURE_SLOTS-1:0] match_s1;
	logic [TEXTURE_SLOTS-1:0] match_d;

	logic                     out_drawn_q;
	logic [SPR_W-1:0]         out_sprites_q;
	logic [SLOT_W-1:0]        out_slot_q;
	logic                     out_cleared_q;

	logic                     is_flush;
	logic                     batch_nz;
	logic                     pre_draw;
	logic                     tex_nz;
	logic                     hit;
	logic [IDX_W-1:0]         hit_idx;
	logic                     full;
	logic                     miss;
	logic                     clear;
	logic                     res_drawn;
	logic [SPR_W-1:0]         batch_base;
	logic [SLOT_W-1:0]        res_slot;
	logic [IDX_W-1:0]         wr_idx;

	assign batch_limit = max_q;
	assign result = {out_cleared_q, out_slot_q, out_sprites_q, out_drawn_q};

	// one comparator per table entry, only entries below the fill count count
	always_comb begin
		for (int i = 0; i < TEXTURE_SLOTS; i++) begin
			match_d[i] = (tab_q[i] == item_tex_q) && (COUNT_W'(i) < count_q);
		end
	end

	// lowest matching entry wins
	always_comb begin
		hit_idx = '0;
		for (int i = TEXTURE_SLOTS - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign is_flush = (op_q == OP_FLUSH);
	assign batch_nz = (batch_q != '0);
	assign pre_draw = (batch_nz && known_q && (shader_q != item_shader_q)) ||
		(batch_q >= max_q);
	assign tex_nz   = (item_tex_q != '0);
	assign hit      = |match_s1;
	assign full     = (count_q >= COUNT_W'(TEXTURE_SLOTS));
	assign miss     = !is_flush && tex_nz && !hit;
	assign clear    = miss && full;
	// at most one draw per item: a late full-table draw only happens with no early one
	assign res_drawn  = batch_nz && (is_flush || pre_draw || clear);
	assign batch_base = (pre_draw || clear) ? '0 : batch_q;
	assign wr_idx     = clear ? '0 : count_q[IDX_W-1:0];

	always_comb begin
		if (is_flush || !tex_nz) begin
			res_slot = '0;
		end else if (hit) begin
			res_slot = SLOT_W'({1'b0, hit_idx} + 1'b1);
		end else if (clear) begin
			res_slot = SLOT_W'(1);
		end else begin
			res_slot = SLOT_W'({1'b0, count_q} + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			batch_q  <= '0;
			shader_q <= '0;
			known_q  <= 1'b0;
			max_q    <= SPRITE_LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (cmd.commit) begin
				if (is_flush) begin
					batch_q <= '0;
				end else begin
					shader_q <= item_shader_q;
					known_q  <= 1'b1;
					batch_q  <= (batch_base == SPR_SAT) ? batch_base : batch_base + 1'b1;
					if (clear) begin
						count_q <= COUNT_W'(1);
					end else if (miss) begin
						count_q <= count_q + 1'b1;
					end
				end
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q          <= in_op;
			item_shader_q <= in_shader;
			item_tex_q    <= in_texture;
		end
		if (cmd.load_match) begin
			match_s1 <= match_d;
		end
		if (cmd.commit) begin
			if (miss) begin
				tab_q[wr_idx] <= item_tex_q;
			end
			out_drawn_q   <= res_drawn;
			out_sprites_q <= res_drawn ? batch_q : '0;
			out_slot_q    <= res_slot;
			out_cleared_q <= clear;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(TEXTURE_SLOTS))
		else $error("texture count beyond table size");
	a_draw_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (!out_drawn_q || (out_sprites_q != '0)))
		else $error("drawn batch reported empty");
	a_clear_refills: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && clear) |=> (count_q == COUNT_W'(1)))
		else $error("cleared table not restarted with one entry");
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_flush) |=> (batch_q == '0))
		else $error("flush left sprites in batch");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for sprite_batch_texture_slot_allocator: sprite and flush beats in,
// slot results checked against a cycle-free model of batch and texture table state
// depends on sbtsa_pkg and the sprite_batch_texture_slot_allocator rtl

module testbench;
	import sbtsa_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 4;
	localparam int HOLD_CYCLES   = 80;
	localparam int WATCHDOG_MAX  = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int SHADER_POOL   = 4;
	localparam int TEX_POOL_MAX  = 40;
	localparam int PRINT_CAP     = 40;
	localparam logic [PADDR_W-1:0] SPRITE_LIMIT_ADDR = {REG_SPRITE_LIMIT, 2'b00};

	// lowest field first: batch_drawn, drawn_sprites, texture_slot, table_cleared
	typedef struct packed {
		logic              table_cleared;
		logic [SLOT_W-1:0] texture_slot;
		logic [SPR_W-1:0]  drawn_sprites;
		logic              batch_drawn;
	} slot_beat_t;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} ready_mode_t;

	class slot_ledger_t;
		logic [ID_W-1:0]  tex_table [TEXTURE_SLOTS];
		int               tex_count;
		logic [SPR_W-1:0] batch_fill;
		logic [ID_W-1:0]  cur_shader;
		bit               shader_valid;
		logic [SPR_W-1:0] sprite_limit;
		slot_beat_t       owed_beats [$];
		int               errors;
		int               beats_seen;
		int               draws_seen;
		int               clears_seen;

		function new();
			tex_count    = 0;
			batch_fill   = '0;
			cur_shader   = '0;
			shader_valid = 1'b0;
			sprite_limit = SPRITE_LIMIT_RESET;
			errors       = 0;
			beats_seen   = 0;
			draws_seen   = 0;
			clears_seen  = 0;
		endfunction

		function void set_limit(logic [SPR_W-1:0] value);
			sprite_limit = value;
		endfunction

		function int pending();
			return owed_beats.size();
		endfunction

		function void close_batch(inout slot_beat_t r);
			if (batch_fill != '0) begin
				r.batch_drawn   = 1'b1;
				r.drawn_sprites = batch_fill;
				batch_fill      = '0;
			end
		endfunction

		// works out the result of one accepted input beat and queues it
		function void take_sprite(logic [OP_W-1:0] op, logic [ID_W-1:0] shader,
				logic [ID_W-1:0] tex);
			slot_beat_t r;
			bit hit;
			int n;
			r = '0;
			if (op == OP_FLUSH) begin
				close_batch(r);
			end else begin
				if ((batch_fill != '0 && shader_valid && cur_shader != shader) ||
						batch_fill >= sprite_limit)
					close_batch(r);
				cur_shader   = shader;
				shader_valid = 1'b1;
				if (tex != '0) begin
					hit = 1'b0;
					n = tex_count;
					for (int i = 0; i < n; i++) begin
						if (!hit && tex_table[i] == tex) begin
							r.texture_slot = SLOT_W'(i + 1);
							hit = 1'b1;
						end
					end
					if (!hit) begin
						// full table: draw what is open, then start the table over
						if (n >= TEXTURE_SLOTS) begin
							close_batch(r);
							n = 0;
							r.table_cleared = 1'b1;
						end
						tex_table[n] = tex;
						n++;
						tex_count = n;
						r.texture_slot = SLOT_W'(n);
					end
				end
				if (batch_fill != SPR_SAT)
					batch_fill++;
			end
			owed_beats.insert(owed_beats.size(), r);
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
			end
		endfunction

		function void match_beat(slot_beat_t got);
			slot_beat_t want;
			if (owed_beats.size() == 0) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t ns: result beat with nothing pending, expected none, got %h",
						$time, got);
				return;
			end
			want = owed_beats.pop_front();
			beats_seen++;
			if (want.batch_drawn)
				draws_seen++;
			if (want.table_cleared)
				clears_seen++;
			flag("batch_drawn", 32'(want.batch_drawn), 32'(got.batch_drawn));
			flag("drawn_sprites", 32'(want.drawn_sprites), 32'(got.drawn_sprites));
			flag("texture_slot", 32'(want.texture_slot), 32'(got.texture_slot));
			flag("table_cleared", 32'(want.table_cleared), 32'(got.table_cleared));
		endfunction

		function void check_reg(logic [APB_DW-1:0] got);
			flag("sprite limit readback", {{(APB_DW-SPR_W){1'b0}}, sprite_limit}, got);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;   // shader_id, texture_id
	logic [OP_W-1:0]     s_tuser;   // op
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;   // batch_drawn, drawn_sprites, texture_slot, table_cleared
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	slot_ledger_t    ledger;
	bit              hold_req;
	int              idle_cycles;
	int              settings_used;
	int              shader_sel;
	int              pool_size;
	logic [ID_W-1:0] shader_pool [SHADER_POOL];
	logic [ID_W-1:0] tex_pool [TEX_POOL_MAX];

	sprite_batch_texture_slot_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// result checking and the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				ledger.match_beat(slot_beat_t'(m_tdata));
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_MAX);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		ready_mode_t mode;
		int left;
		int tick;
		m_tready = 1'b0;
		mode = READY_ALWAYS;
		left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = ready_mode_t'($urandom_range(0, 3));
					left = $urandom_range(20, 120);
				end
				left--;
				tick++;
				case (mode)
					READY_ALWAYS:  m_tready <= 1'b1;
					READY_COIN:    m_tready <= $urandom_range(0, 1);
					READY_MOSTLY:  m_tready <= ($urandom_range(0, 4) != 0);
					default:       m_tready <= ((tick % 7) < 4);
				endcase
			end
		end
	end

	// offers one beat and returns at the falling edge after it was taken
	task automatic push_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] shader,
			input logic [ID_W-1:0] tex);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {tex, shader};
		do @(posedge clk); while (!s_tready);
		ledger.take_sprite(op, shader, tex);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (ledger.pending() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= SPRITE_LIMIT_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_sprite_limit(input logic [SPR_W-1:0] value);
		logic [APB_DW-1:0] rd;
		wait_drained();
		// upper bits carry noise, only the low half is the register
		apb_access(1'b1, {16'($urandom_range(0, 16'hFFFF)), value}, rd);
		ledger.set_limit(value);
		apb_access(1'b0, '0, rd);
		ledger.check_reg(rd);
		settings_used++;
	endtask

	task automatic refill_pools(input int size);
		pool_size = size;
		for (int i = 0; i < SHADER_POOL; i++)
			shader_pool[i] = $urandom;
		for (int i = 0; i < TEX_POOL_MAX; i++) begin
			tex_pool[i] = $urandom;
			if (tex_pool[i] == '0)
				tex_pool[i] = 1;
		end
	endtask

	// runs of one shader from a texture pool, with some noise and flushes
	task automatic pick_item(output logic [OP_W-1:0] op, output logic [ID_W-1:0] shader,
			output logic [ID_W-1:0] tex);
		int roll;
		roll = $urandom_range(0, 99);
		op = (roll < 8) ? OP_FLUSH : OP_SUBMIT;
		if ($urandom_range(0, 11) == 0)
			shader_sel = $urandom_range(0, SHADER_POOL - 1);
		shader = ($urandom_range(0, 19) == 0) ? $urandom : shader_pool[shader_sel];
		roll = $urandom_range(0, 99);
		if (roll < 10)
			tex = '0;
		else if (roll < 88)
			tex = tex_pool[$urandom_range(0, pool_size - 1)];
		else
			tex = $urandom;
	endtask

	task automatic send_random(input int count, input bit gapless);
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] shader;
		logic [ID_W-1:0] tex;
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 20);
		for (int k = 0; k < count; k++) begin
			pick_item(op, shader, tex);
			push_item(op, shader, tex);
			if (burst_left == 0 && !gapless) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end else if (burst_left != 0) begin
				burst_left--;
			end
		end
	endtask

	task automatic run_phase(input logic [SPR_W-1:0] value, input int count, input int size);
		set_sprite_limit(value);
		refill_pools(size);
		send_random(count, 1'b0);
	endtask

	initial begin
		ledger        = new();
		hold_req      = 1'b0;
		idle_cycles   = 0;
		settings_used = 0;
		shader_sel    = 0;
		pool_size     = 1;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = OP_SUBMIT;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty flush, first shader, hits and misses, shader change, id extremes
		push_item(OP_FLUSH, '0, '0);
		push_item(OP_SUBMIT, 32'd5, '0);
		push_item(OP_SUBMIT, 32'd5, 32'hFFFF_FFFF);
		push_item(OP_SUBMIT, 32'd5, 32'hFFFF_FFFF);
		push_item(OP_SUBMIT, 32'd5, 32'd1);
		push_item(OP_SUBMIT, 32'hFFFF_FFFF, 32'd1);
		push_item(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(OP_FLUSH, '0, '0);
		push_item(OP_SUBMIT, '0, 32'h8000_0000);
		push_item(OP_SUBMIT, '0, '0);
		push_item(OP_SUBMIT, '0, 32'h5555_5555);
		push_item(OP_SUBMIT, '0, 32'hAAAA_AAAA);
		// limit dropped below the open batch: next submit draws it
		set_sprite_limit(16'd2);
		push_item(OP_SUBMIT, '0, 32'h5555_5555);
		push_item(OP_SUBMIT, '0, 32'd1);
		push_item(OP_SUBMIT, '0, 32'h8000_0000);
		push_item(OP_SUBMIT, 32'h0000_0001, 32'hFFFF_FFFF);
		// zero limit draws at every submit
		set_sprite_limit(16'd0);
		push_item(OP_SUBMIT, 32'h0000_0001, 32'd7);
		push_item(OP_SUBMIT, 32'h0000_0001, 32'd7);
		push_item(OP_SUBMIT, 32'h0000_0002, '0);
		push_item(OP_FLUSH, '0, '0);
		push_item(OP_FLUSH, '0, '0);

		run_phase(SPR_SAT, 60, 40);
		// long receiver hold while the sender keeps offering
		hold_req = 1'b1;
		send_random(30, 1'b1);
		wait_drained();
		send_random(30, 1'b0);
		run_phase(16'd1, 60, 20);
		run_phase(16'd0, 50, 40);
		run_phase(16'd3, 60, 40);
		run_phase(16'($urandom_range(4, 64)), 60, 36);
		run_phase(SPRITE_LIMIT_RESET, 60, 40);
		run_phase(16'($urandom_range(0, 16'hFFFF)), 40, 40);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d result beats under %0d sprite limit settings",
			ledger.beats_seen, settings_used);
		$display("  with %0d batch draws and %0d texture table clears",
			ledger.draws_seen, ledger.clears_seen);
		if (ledger.errors == 0 && ledger.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sprite_batch_texture_slot_allocator.f
sv/sbtsa_pkg.sv
sv/sbtsa_ctrl.sv
sv/sbtsa_dp.sv
sv/sprite_batch_texture_slot_allocator.sv
tb/testbench.sv
